>>> design/gpr_pkg.sv
`default_nettype none

package gpr_pkg;

	// Fixed widths of the words on both channels.
	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int PORT_W = 3;
	localparam int SEL_W  = 4;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;

	// Register selects.
	localparam logic [SEL_W-1:0] REG_DIR       = 4'd0;
	localparam logic [SEL_W-1:0] REG_MASK      = 4'd1;
	localparam logic [SEL_W-1:0] REG_PIN       = 4'd2;
	localparam logic [SEL_W-1:0] REG_SET       = 4'd3;
	localparam logic [SEL_W-1:0] REG_CLR       = 4'd4;
	localparam logic [SEL_W-1:0] REG_RISE_EN   = 4'd5;
	localparam logic [SEL_W-1:0] REG_FALL_EN   = 4'd6;
	localparam logic [SEL_W-1:0] REG_RISE_STAT = 4'd7;
	localparam logic [SEL_W-1:0] REG_FALL_STAT = 4'd8;
	localparam logic [SEL_W-1:0] REG_INT_CLR   = 4'd9;

	// Ports that carry edge detection.
	localparam logic [PORT_W-1:0] EDGE_PORT_A = 3'd0;
	localparam logic [PORT_W-1:0] EDGE_PORT_B = 3'd2;
	localparam int EDGE_SLOTS = 2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [PORT_W-1:0] port;
		logic [SEL_W-1:0]  reg_select;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] pin_levels;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              access_error;
		logic [DATA_W-1:0] out_latch;
		logic [DATA_W-1:0] drive_enable;
		logic              irq;
	} rsp_t;

endpackage

`default_nettype wire

>>> design/gpr_in_reg.sv
`default_nettype none

module gpr_in_reg
	import gpr_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	input  wire  advance,
	output logic valid_s1,
	output req_t item_s1
);

	logic load;

	// The stage takes a new word when it is empty or its word moves on.
	assign load      = !valid_s1 || advance;
	assign req_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && req_valid) begin
			item_s1 <= req;
		end
	end

endmodule

`default_nettype wire

>>> design/gpr_core.sv
`default_nettype none

module gpr_core
	import gpr_pkg::*;
#(
	parameter int NUM_PORTS  = 5,
	parameter int PORT_WIDTH = 32
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  fire,
	input  req_t item,
	output rsp_t result
);

	localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int PW     = PORT_WIDTH;

	logic [PW-1:0] dir_q  [NUM_PORTS];
	logic [PW-1:0] mask_q [NUM_PORTS];
	logic [PW-1:0] lat_q  [NUM_PORTS];
	logic [PW-1:0] smp_q  [NUM_PORTS];
	logic [PW-1:0] ren_q  [EDGE_SLOTS];
	logic [PW-1:0] fen_q  [EDGE_SLOTS];
	logic [PW-1:0] rst_q  [EDGE_SLOTS];
	logic [PW-1:0] fst_q  [EDGE_SLOTS];

	logic [PIDX_W-1:0] pi;
	logic              slot;
	logic              port_ok;
	logic              cmd_ok;
	logic              is_edge;
	logic [PW-1:0]     wd, lv, unm;
	logic [PW-1:0]     dir_c, mask_c, lat_c, smp_c, ren_c, fen_c, rst_c, fst_c;
	logic [PW-1:0]     dir_n, mask_n, lat_n, smp_n, ren_n, fen_n, rst_n, fst_n;
	logic [PW-1:0]     rd;
	logic              err;
	logic              we;
	logic              edge_we;
	logic              irq_n;

	assign pi      = item.port[PIDX_W-1:0];
	assign slot    = (item.port == EDGE_PORT_B);
	assign port_ok = ({1'b0, item.port} < (PORT_W + 1)'(NUM_PORTS));
	// An undefined command reports no port view, just like a bad port.
	assign cmd_ok  = item.command inside {CMD_SAMPLE, CMD_READ, CMD_WRITE};
	assign is_edge = (item.port == EDGE_PORT_A) || (item.port == EDGE_PORT_B);
	assign wd      = item.write_data[PW-1:0];
	assign lv      = item.pin_levels[PW-1:0];

	assign dir_c  = dir_q[pi];
	assign mask_c = mask_q[pi];
	assign lat_c  = lat_q[pi];
	assign smp_c  = smp_q[pi];
	assign ren_c  = ren_q[slot];
	assign fen_c  = fen_q[slot];
	assign rst_c  = rst_q[slot];
	assign fst_c  = fst_q[slot];
	assign unm    = ~mask_c;

	always_comb begin
		dir_n  = dir_c;
		mask_n = mask_c;
		lat_n  = lat_c;
		smp_n  = smp_c;
		ren_n  = ren_c;
		fen_n  = fen_c;
		rst_n  = rst_c;
		fst_n  = fst_c;
		rd     = '0;
		err    = 1'b0;
		case (item.command)
			CMD_SAMPLE: begin
				if (is_edge) begin
					rst_n = rst_c | (~smp_c & lv & ren_c);
					fst_n = fst_c | (smp_c & ~lv & fen_c);
				end
				smp_n = lv;
			end
			CMD_READ: begin
				case (item.reg_select)
					REG_DIR:       rd = dir_c;
					REG_MASK:      rd = mask_c;
					REG_PIN:       rd = smp_c & unm;
					REG_SET:       rd = lat_c & unm;
					REG_CLR:       rd = '0;
					REG_RISE_EN:   if (is_edge) rd = ren_c; else err = 1'b1;
					REG_FALL_EN:   if (is_edge) rd = fen_c; else err = 1'b1;
					REG_RISE_STAT: if (is_edge) rd = rst_c; else err = 1'b1;
					REG_FALL_STAT: if (is_edge) rd = fst_c; else err = 1'b1;
					REG_INT_CLR:   err = !is_edge;
					default:       err = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				case (item.reg_select)
					REG_DIR:  dir_n  = wd;
					REG_MASK: mask_n = wd;
					REG_PIN:  lat_n  = (lat_c & mask_c) | (wd & unm);
					REG_SET:  lat_n  = lat_c | (wd & unm);
					REG_CLR:  lat_n  = lat_c & ~(wd & unm);
					REG_RISE_EN: begin
						if (is_edge) ren_n = wd; else err = 1'b1;
					end
					REG_FALL_EN: begin
						if (is_edge) fen_n = wd; else err = 1'b1;
					end
					REG_INT_CLR: begin
						if (is_edge) begin
							rst_n = rst_c & ~wd;
							fst_n = fst_c & ~wd;
						end else begin
							err = 1'b1;
						end
					end
					default: err = 1'b1;
				endcase
			end
			default: err = 1'b1;
		endcase
		if (!port_ok) begin
			err = 1'b1;
			rd  = '0;
		end
	end

	// Rejected items leave every next value equal to the current one, so the
	// enables only need to exclude an out-of-range port.
	assign we      = fire && port_ok;
	assign edge_we = we && is_edge;

	always_comb begin
		irq_n = 1'b0;
		for (int i = 0; i < EDGE_SLOTS; i++) begin
			if (edge_we && (slot == i[0])) begin
				irq_n = irq_n | (|(rst_n | fst_n));
			end else begin
				irq_n = irq_n | (|(rst_q[i] | fst_q[i]));
			end
		end
	end

	always_comb begin
		result.read_data    = DATA_W'(rd);
		result.access_error = err;
		result.out_latch    = (port_ok && cmd_ok) ? DATA_W'(lat_n) : '0;
		result.drive_enable = (port_ok && cmd_ok) ? DATA_W'(dir_n) : '0;
		result.irq          = irq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				dir_q[i]  <= '0;
				mask_q[i] <= '0;
				lat_q[i]  <= '0;
				smp_q[i]  <= '0;
			end
		end else if (we) begin
			dir_q[pi]  <= dir_n;
			mask_q[pi] <= mask_n;
			lat_q[pi]  <= lat_n;
			smp_q[pi]  <= smp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EDGE_SLOTS; i++) begin
				ren_q[i] <= '0;
				fen_q[i] <= '0;
				rst_q[i] <= '0;
				fst_q[i] <= '0;
			end
		end else if (edge_we) begin
			ren_q[slot] <= ren_n;
			fen_q[slot] <= fen_n;
			rst_q[slot] <= rst_n;
			fst_q[slot] <= fst_n;
		end
	end

	// A direction write to a valid port lands in that port's register.
	a_dir_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire && port_ok && item.command == CMD_WRITE && item.reg_select == REG_DIR
		|=> dir_q[$past(pi)] == $past(wd))
		else $error("direction write lost");

	// Port 0 rise status bits are sticky unless an interrupt clear hits port 0.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && item.port == EDGE_PORT_A && item.command == CMD_WRITE &&
		  item.reg_select == REG_INT_CLR)
		|=> (rst_q[0] & $past(rst_q[0])) == $past(rst_q[0]))
		else $error("rise status bit dropped without a clear");

	// An out-of-range port always reports an error and no register data.
	a_bad_port: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !port_ok |-> result.access_error && result.read_data == '0)
		else $error("out-of-range port not rejected");

endmodule

`default_nettype wire

>>> design/gpr_out_reg.sv
`default_nettype none

module gpr_out_reg
	import gpr_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  valid_s1,
	input  rsp_t result,
	input  wire  rsp_stall,
	output logic advance,
	output logic rsp_valid,
	output rsp_t rsp
);

	logic valid_s2;
	rsp_t rsp_s2;

	// The result register takes a word when it is empty or being drained.
	assign advance   = !valid_s2 || !rsp_stall;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= result;
		end
	end

endmodule

`default_nettype wire

>>> design/gpio_port_register_block_top.sv
// An accepted word waits in the input register, then is registered as the result.
// Throughput: one word per cycle while the receiver does not stall the result register.
// The input register and the result register each stall only when full and blocked.
// Reset (arst_n low, asynchronous) empties both stages and zeroes every port register.
`default_nettype none

module gpio_port_register_block_top
	import gpr_pkg::*;
#(
	parameter int NUM_PORTS  = 5,
	parameter int PORT_WIDTH = 32
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	// Stage one holds the accepted request word.
	logic valid_s1;
	req_t item_s1;

	// The result stage tells stage one when its word may move on.
	logic advance;
	logic fire;

	rsp_t result;

	// A request is executed against the port registers in the same cycle
	// that it moves into the result register, so the next word always sees
	// the state left by the previous one.
	assign fire = valid_s1 && advance;

	gpr_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// The register file and its update logic: direction, mask, output latch
	// and sampled levels for each port, plus edge enables and sticky status
	// for the edge-capable ports EDGE_PORT_A and EDGE_PORT_B.
	gpr_core #(
		.NUM_PORTS  (NUM_PORTS),
		.PORT_WIDTH (PORT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	gpr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.rsp_stall (rsp_stall),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> test/tb_gpio_port_register_block_top.sv
`timescale 1ns / 100ps

module tb_gpio_port_register_block_top;

	import gpr_pkg::*;

	// The block is built with five ports of full width, which is what the
	// predictor below mirrors.
	localparam int PORTS      = 5;
	localparam int PINS       = 32;
	localparam int CLK_HALF   = 10;
	localparam int RESET_CYC  = 5;
	// A tail of idle cycles before the verdict, so that a stray extra word
	// would still be seen by the checker.
	localparam int TAIL_CYC   = 10;
	// Around 450 words, each at worst paying a long sender gap, a long
	// receiver stall and the pipeline latency: far below this bound.
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT  = 10;

	// Command 3 and the register selects above the interrupt clear are not
	// defined by the block; they are driven on purpose to hit the error path.
	localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [SEL_W-1:0]  REG_LAST_SEL = {SEL_W{1'b1}};
	localparam logic [PORT_W-1:0] PORT_LAST    = {PORT_W{1'b1}};
	localparam logic [PORT_W-1:0] PORT_TOP     = PORT_W'(PORTS - 1);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Clock: 20 ns period, two delays per cycle.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	gpio_port_register_block_top #(
		.NUM_PORTS (PORTS),
		.PORT_WIDTH(PINS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// ------------------------------------------------------------------
	// Predictor state: a private copy of every port register. The edge
	// registers exist only for the edge ports A and B and are indexed by slot.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] port_dir    [PORTS];
	logic [DATA_W-1:0] port_mask   [PORTS];
	logic [DATA_W-1:0] port_latch  [PORTS];
	logic [DATA_W-1:0] port_levels [PORTS];
	logic [DATA_W-1:0] rise_en     [EDGE_SLOTS];
	logic [DATA_W-1:0] fall_en     [EDGE_SLOTS];
	logic [DATA_W-1:0] rise_seen   [EDGE_SLOTS];
	logic [DATA_W-1:0] fall_seen   [EDGE_SLOTS];

	// Responses the block owes us, oldest first.
	rsp_t expected_responses [$];

	int unsigned fail_count  = 0;
	int unsigned shown_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	// When set, neither side inserts gaps or stalls.
	bit          no_idle     = 1'b0;

	// Edge slot of a port, or -1 for a port without edge detection.
	function automatic int edge_slot(input logic [PORT_W-1:0] p);
		if (p == EDGE_PORT_A)
			return 0;
		if (p == EDGE_PORT_B)
			return 1;
		return -1;
	endfunction

	// Applies one word to the predictor state and returns the response the
	// block must produce for it.
	function automatic rsp_t predict_gpio_response(input req_t w);
		rsp_t              r;
		logic              err;
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] unm;
		logic [DATA_W-1:0] wd;
		int                p;
		int                slot;
		r   = '0;
		err = 1'b0;
		rd  = '0;
		wd  = w.write_data;
		p   = int'(w.port);
		if (p >= PORTS || w.command == CMD_UNUSED) begin
			// Nothing changes and the port view reads as zero.
			err = 1'b1;
		end else begin
			slot = edge_slot(w.port);
			unm  = ~port_mask[p];
			case (w.command)
			CMD_SAMPLE: begin
				// Edges are caught regardless of direction or mask.
				if (slot >= 0) begin
					rise_seen[slot] |= ~port_levels[p] & w.pin_levels & rise_en[slot];
					fall_seen[slot] |= port_levels[p] & ~w.pin_levels & fall_en[slot];
				end
				port_levels[p] = w.pin_levels;
			end
			CMD_READ: begin
				case (w.reg_select)
				REG_DIR:  rd = port_dir[p];
				REG_MASK: rd = port_mask[p];
				REG_PIN:  rd = port_levels[p] & unm;
				REG_SET:  rd = port_latch[p] & unm;
				REG_CLR:  rd = '0;
				REG_RISE_EN, REG_FALL_EN, REG_RISE_STAT, REG_FALL_STAT, REG_INT_CLR: begin
					if (slot < 0) begin
						err = 1'b1;
					end else begin
						case (w.reg_select)
						REG_RISE_EN:   rd = rise_en[slot];
						REG_FALL_EN:   rd = fall_en[slot];
						REG_RISE_STAT: rd = rise_seen[slot];
						REG_FALL_STAT: rd = fall_seen[slot];
						default:       rd = '0;
						endcase
					end
				end
				default: err = 1'b1;
				endcase
			end
			default: begin
				// Only a write is left here.
				case (w.reg_select)
				REG_DIR:  port_dir[p]   = wd;
				REG_MASK: port_mask[p]  = wd;
				REG_PIN:  port_latch[p] = (port_latch[p] & ~unm) | (wd & unm);
				REG_SET:  port_latch[p] = port_latch[p] | (wd & unm);
				REG_CLR:  port_latch[p] = port_latch[p] & ~(wd & unm);
				REG_RISE_EN, REG_FALL_EN, REG_INT_CLR: begin
					if (slot < 0) begin
						err = 1'b1;
					end else begin
						case (w.reg_select)
						REG_RISE_EN: rise_en[slot] = wd;
						REG_FALL_EN: fall_en[slot] = wd;
						default: begin
							rise_seen[slot] &= ~wd;
							fall_seen[slot] &= ~wd;
						end
						endcase
					end
				end
				// Status registers are read-only, anything else is absent.
				default: err = 1'b1;
				endcase
			end
			endcase
			r.out_latch    = port_latch[p];
			r.drive_enable = port_dir[p];
		end
		r.access_error = err;
		r.read_data    = err ? '0 : rd;
		r.irq          = 1'b0;
		for (int s = 0; s < EDGE_SLOTS; s++)
			if ((rise_seen[s] | fall_seen[s]) != '0)
				r.irq = 1'b1;
		return r;
	endfunction

	// Gap lengths: mostly none, often short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_word(input logic [CMD_W-1:0] cmd,
			input logic [PORT_W-1:0] p, input logic [SEL_W-1:0] sel,
			input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] lv);
		req_t w;
		w.command    = cmd;
		w.port       = p;
		w.reg_select = sel;
		w.write_data = wd;
		w.pin_levels = lv;
		return w;
	endfunction

	// A defined access to an existing port with random content.
	function automatic req_t legal_word();
		return make_word(CMD_W'($urandom_range(CMD_SAMPLE, CMD_WRITE)),
			PORT_W'($urandom_range(0, PORTS - 1)),
			SEL_W'($urandom_range(REG_DIR, REG_INT_CLR)), $urandom, $urandom);
	endfunction

	// Random data that lands on the all-zero and all-one corners now and then.
	function automatic logic [DATA_W-1:0] pin_pattern();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [PORT_W-1:0] pick_edge_port();
		return $urandom_range(0, 1) ? EDGE_PORT_B : EDGE_PORT_A;
	endfunction

	// ------------------------------------------------------------------
	// Sender side. A word is driven at the falling edge and held until a
	// rising edge sees valid high and stall low. Valid is only lowered when
	// a gap follows, so it is never dropped and raised in the same step.
	// ------------------------------------------------------------------
	task automatic hold_off_sender(input int unsigned cycles);
		if (cycles != 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_word(input req_t w);
		@(negedge clk);
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_responses.push_back(predict_gpio_response(w));
		hold_off_sender(pick_gap());
	endtask

	task automatic write_reg(input logic [PORT_W-1:0] p, input logic [SEL_W-1:0] sel,
			input logic [DATA_W-1:0] wd);
		send_word(make_word(CMD_WRITE, p, sel, wd, $urandom));
	endtask

	task automatic read_reg(input logic [PORT_W-1:0] p, input logic [SEL_W-1:0] sel);
		send_word(make_word(CMD_READ, p, sel, $urandom, $urandom));
	endtask

	task automatic sample_pins(input logic [PORT_W-1:0] p, input logic [DATA_W-1:0] lv);
		send_word(make_word(CMD_SAMPLE, p, REG_DIR, $urandom, lv));
	endtask

	// Stops sending until the block has returned every response it owes.
	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver side: stall runs of random length, changed at falling edges.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left == 0 || no_idle) begin
			rsp_stall  <= 1'b0;
			stall_left = pick_gap();
		end else begin
			rsp_stall  <= 1'b1;
			stall_left = stall_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// Response checker: every accepted word is compared field by field with
	// the oldest prediction. Values are read at the rising edge, before the
	// block updates them.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_response
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_responses.size() == 0) begin
				fail_count++;
				if (shown_count < SHOW_LIMIT) begin
					shown_count++;
					$display("unexpected response word: data %h err %b latch %h dir %h irq %b",
						rsp.read_data, rsp.access_error, rsp.out_latch, rsp.drive_enable,
						rsp.irq);
				end
			end else begin
				want = expected_responses.pop_front();
				if (rsp.read_data !== want.read_data || rsp.access_error !== want.access_error
						|| rsp.out_latch !== want.out_latch
						|| rsp.drive_enable !== want.drive_enable || rsp.irq !== want.irq) begin
					fail_count++;
					if (shown_count < SHOW_LIMIT) begin
						shown_count++;
						$display("response mismatch at %0t:", $realtime);
						$display("  expected data %h err %b latch %h dir %h irq %b",
							want.read_data, want.access_error, want.out_latch,
							want.drive_enable, want.irq);
						$display("  actual   data %h err %b latch %h dir %h irq %b",
							rsp.read_data, rsp.access_error, rsp.out_latch,
							rsp.drive_enable, rsp.irq);
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values, every register and command once, the corner data
	// patterns, and each way an access can be refused.
	task automatic test_directed();
		read_reg(EDGE_PORT_A, REG_DIR);
		read_reg(PORT_TOP, REG_PIN);
		write_reg(PORT_TOP, REG_DIR, '1);
		write_reg(PORT_TOP, REG_MASK, 32'h0000_FFFF);
		// Only the upper half of the latch is open to the pin write.
		write_reg(PORT_TOP, REG_PIN, '1);
		write_reg(PORT_TOP, REG_SET, '1);
		write_reg(PORT_TOP, REG_CLR, 32'hFFFF_0000);
		read_reg(PORT_TOP, REG_SET);
		// The clear register is write-only and reads as zero without error.
		read_reg(PORT_TOP, REG_CLR);
		write_reg(EDGE_PORT_A, REG_RISE_EN, '1);
		write_reg(EDGE_PORT_A, REG_FALL_EN, '1);
		sample_pins(EDGE_PORT_A, '1);
		sample_pins(EDGE_PORT_A, '0);
		read_reg(EDGE_PORT_A, REG_RISE_STAT);
		read_reg(EDGE_PORT_A, REG_FALL_STAT);
		read_reg(EDGE_PORT_A, REG_INT_CLR);
		write_reg(EDGE_PORT_A, REG_INT_CLR, '1);
		// Status registers cannot be written.
		write_reg(EDGE_PORT_A, REG_RISE_STAT, '1);
		// Edge registers are missing on ports without edge detection.
		read_reg(3'd1, REG_RISE_EN);
		write_reg(3'd3, REG_INT_CLR, '1);
		// Register select past the last register.
		read_reg(EDGE_PORT_B, REG_LAST_SEL);
		// Undefined command on a good port.
		send_word(make_word(CMD_UNUSED, EDGE_PORT_A, REG_DIR, '1, '1));
		// Ports past the last one refuse every command.
		read_reg(PORT_LAST, REG_DIR);
		sample_pins(PORT_W'(PORTS), '1);
		read_reg(EDGE_PORT_B, REG_FALL_EN);
	endtask

	// Legal words with neither side ever idling.
	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (40)
			send_word(legal_word());
		no_idle = 1'b0;
	endtask

	// Arm the edge enables on an edge port, feed it a train of pin samples,
	// read the sticky status back and clear part of it.
	task automatic test_edge_sequences();
		logic [PORT_W-1:0] p;
		repeat (18) begin
			p = pick_edge_port();
			write_reg(p, REG_RISE_EN, pin_pattern());
			write_reg(p, REG_FALL_EN, pin_pattern());
			if ($urandom_range(0, 3) == 0)
				write_reg(p, REG_MASK, pin_pattern());
			repeat ($urandom_range(2, 4))
				sample_pins(p, pin_pattern());
			read_reg(p, REG_RISE_STAT);
			read_reg(p, REG_FALL_STAT);
			read_reg(p, REG_PIN);
			write_reg(p, REG_INT_CLR, pin_pattern());
		end
	endtask

	// Mask, direction and latch traffic on random ports.
	task automatic test_masked_latch();
		logic [PORT_W-1:0] p;
		logic [SEL_W-1:0]  sel;
		repeat (10) begin
			p = PORT_W'($urandom_range(0, PORTS - 1));
			write_reg(p, REG_MASK, pin_pattern());
			write_reg(p, REG_DIR, pin_pattern());
			repeat (4) begin
				sel = SEL_W'($urandom_range(REG_PIN, REG_CLR));
				write_reg(p, sel, pin_pattern());
			end
			sample_pins(p, pin_pattern());
			read_reg(p, REG_SET);
			read_reg(p, REG_PIN);
			read_reg(p, REG_MASK);
			read_reg(p, REG_DIR);
		end
	endtask

	// Bursts of legal words, each followed by a pause until all responses
	// are back, so the block starts each burst from empty.
	task automatic test_drain_pause();
		repeat (3) begin
			repeat (10)
				send_word(legal_word());
			drain_responses();
		end
	endtask

	// Every field fully random, including undefined commands, ports and
	// register selects.
	task automatic test_random_noise();
		repeat (80)
			send_word(make_word(CMD_W'($urandom), PORT_W'($urandom), SEL_W'($urandom),
				$urandom, $urandom));
	endtask

	initial begin
		for (int p = 0; p < PORTS; p++) begin
			port_dir[p]    = '0;
			port_mask[p]   = '0;
			port_latch[p]  = '0;
			port_levels[p] = '0;
		end
		for (int s = 0; s < EDGE_SLOTS; s++) begin
			rise_en[s]   = '0;
			fall_en[s]   = '0;
			rise_seen[s] = '0;
			fall_seen[s] = '0;
		end

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_back_to_back();
		test_edge_sequences();
		test_masked_latch();
		test_drain_pause();
		test_random_noise();

		// Wait for the last responses; the watchdog bounds this wait.
		drain_responses();
		repeat (TAIL_CYC) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
design/gpr_pkg.sv
design/gpr_in_reg.sv
design/gpr_core.sv
design/gpr_out_reg.sv
design/gpio_port_register_block_top.sv
test/tb_gpio_port_register_block_top.sv
